[src/log_domain_product_accumulate_assert.svh]
// Assertion macros for the log-domain product accumulator RTL.
// No dependencies; included by the modules that carry checks.
`ifndef LOG_DOMAIN_PRODUCT_ACCUMULATE_ASSERT_SVH
`define LOG_DOMAIN_PRODUCT_ACCUMULATE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define LDPA_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define LDPA_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/ldpa_pkg.sv]
// Types, constants and the exp2 table for the log-domain product accumulator.
// No dependencies.
package ldpa_pkg;

   localparam logic [31:0] ZERO_CODE = 32'h2000_0000;
   localparam logic [31:0] EXP_FIX   = 32'h4080_0000;
   localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
   localparam int unsigned QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [31:0] weight_code;
      logic [31:0] activation_code;
      logic        restart;
   } req_type;

   typedef struct packed {
      logic [31:0] accumulated_bits;
      logic [31:0] product_bits;
   } rsp_type;

   // Item handed from front to back: linear product and restart flag.
   typedef struct packed {
      logic [31:0] product;
      logic        restart;
   } item_type;

   // exp2 fraction table; entries are multiples of 0x40000, stored as 5-bit steps.
   function automatic logic [22:0] exp2_rom(input logic [5:0] idx);
      logic [4:0] s;
      case (idx)
         6'd0, 6'd1:                   s = 5'd0;
         6'd2, 6'd3, 6'd4:             s = 5'd1;
         6'd5, 6'd6:                   s = 5'd2;
         6'd7, 6'd8, 6'd9:             s = 5'd3;
         6'd10, 6'd11, 6'd12:          s = 5'd4;
         6'd13, 6'd14:                 s = 5'd5;
         6'd15, 6'd16, 6'd17:          s = 5'd6;
         6'd18, 6'd19:                 s = 5'd7;
         6'd20, 6'd21:                 s = 5'd8;
         6'd22, 6'd23, 6'd24:          s = 5'd9;
         6'd25, 6'd26:                 s = 5'd10;
         6'd27, 6'd28:                 s = 5'd11;
         6'd29, 6'd30:                 s = 5'd12;
         6'd31, 6'd32:                 s = 5'd13;
         6'd33, 6'd34:                 s = 5'd14;
         6'd35, 6'd36:                 s = 5'd15;
         6'd37, 6'd38:                 s = 5'd16;
         6'd39, 6'd40:                 s = 5'd17;
         6'd41, 6'd42:                 s = 5'd18;
         6'd43:                        s = 5'd19;
         6'd44, 6'd45:                 s = 5'd20;
         6'd46, 6'd47:                 s = 5'd21;
         6'd48, 6'd49:                 s = 5'd22;
         6'd50:                        s = 5'd23;
         6'd51, 6'd52:                 s = 5'd24;
         6'd53, 6'd54:                 s = 5'd25;
         6'd55:                        s = 5'd26;
         6'd56, 6'd57:                 s = 5'd27;
         6'd58:                        s = 5'd28;
         6'd59, 6'd60:                 s = 5'd29;
         6'd61:                        s = 5'd30;
         default:                      s = 5'd31;
      endcase
      return {s, 18'd0};
   endfunction

endpackage

[src/ldpa_front.sv]
// Front stage: log-domain multiply and conversion of the product to linear FP32.
// Depends on ldpa_pkg.
module ldpa_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ldpa_pkg::req_type  req_data,
   output logic               item_valid,
   input  logic               item_ready,
   output ldpa_pkg::item_type item_data
);

   logic               valid_ff, valid_in;
   ldpa_pkg::item_type item_ff, item_in;
   logic [31:0]        z;
   logic               take;

   assign req_ready = !valid_ff || item_ready;
   assign take      = req_valid && req_ready;

   always_comb begin
      z = req_data.weight_code + req_data.activation_code + ldpa_pkg::EXP_FIX;
      item_in.product = {req_data.weight_code[31] ^ req_data.activation_code[31],
                         z[30:23], ldpa_pkg::exp2_rom(z[22:17])};
      item_in.restart = req_data.restart;
      valid_in = take || (valid_ff && !item_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = item_ff;

endmodule

[src/ldpa_queue.sv]
// Two-entry queue between front and back stages.
// Depends on ldpa_pkg and the assertion macro header.
`include "log_domain_product_accumulate_assert.svh"
module ldpa_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  ldpa_pkg::item_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output ldpa_pkg::item_type pop_data
);

   ldpa_pkg::item_type entry_ff [ldpa_pkg::QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `LDPA_ALWAYS(a_count_bound, clock, reset, count_ff != 2'd3, "queue count out of range")
   `LDPA_ALWAYS(a_ptr_track, clock, reset, (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff), "queue pointers disagree with count")
   `LDPA_NEXT(a_full_after, clock, reset, push && !pop && count_ff == 2'd1, !push_ready, "queue not full after fill")

endmodule

[src/ldpa_back.sv]
// Back stage: FP32 addition into the accumulator and the result register.
// Depends on ldpa_pkg.
module ldpa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               item_valid,
   output logic               item_ready,
   input  ldpa_pkg::item_type item_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ldpa_pkg::rsp_type  rsp_data
);

   function automatic logic [31:0] fp32_add(input logic [31:0] a_in, input logic [31:0] b_in);
      logic [31:0] a, b, r;
      logic [7:0]  ea, eb, ea1, eb1, d;
      logic [22:0] fa, fb;
      logic        sa, sb, found;
      logic [26:0] ma, mb, mbs, lost;
      logic [27:0] sum;
      logic [9:0]  e;
      logic [4:0]  lz, sh;
      logic [24:0] m;
      logic [2:0]  rem;
      a = a_in;
      b = b_in;
      r = 32'd0;
      if ((a[30:23] == 8'hFF && a[22:0] != 23'd0) || (b[30:23] == 8'hFF && b[22:0] != 23'd0)) begin
         r = ldpa_pkg::CANON_NAN;
      end else if (a[30:23] == 8'hFF) begin
         r = (b[30:23] == 8'hFF && a[31] != b[31]) ? ldpa_pkg::CANON_NAN : a;
      end else if (b[30:23] == 8'hFF) begin
         r = b;
      end else begin
         if (b[30:0] > a[30:0]) begin
            a = b_in;
            b = a_in;
         end
         ea = a[30:23];
         eb = b[30:23];
         fa = a[22:0];
         fb = b[22:0];
         sa = a[31];
         sb = b[31];
         ea1 = (ea != 8'd0) ? ea : 8'd1;
         eb1 = (eb != 8'd0) ? eb : 8'd1;
         ma = {(ea != 8'd0), fa, 3'b000};
         mb = {(eb != 8'd0), fb, 3'b000};
         e  = {2'b00, ea1};
         d  = ea1 - eb1;
         if (d >= 8'd27) begin
            mbs = {26'd0, |mb};
         end else begin
            lost = mb << (8'd27 - d);
            mbs  = (mb >> d) | {26'd0, |lost};
         end
         sum = (sa == sb) ? ({1'b0, ma} + {1'b0, mbs}) : ({1'b0, ma} - {1'b0, mbs});
         if (sum == 28'd0) begin
            r = (sa == sb) ? {sa, 31'd0} : 32'd0;
         end else begin
            if (sum[27]) begin
               sum = {1'b0, sum[27:2], sum[1] | sum[0]};
               e   = e + 10'd1;
            end else begin
               // Leading-zero count below the hidden-bit position, capped by exponent
               found = 1'b0;
               lz    = 5'd0;
               for (int i = 26; i >= 0; i--) begin
                  if (!found && sum[i]) begin
                     found = 1'b1;
                     lz    = 5'(26 - i);
                  end
               end
               sh  = ({5'd0, lz} > (e - 10'd1)) ? 5'(e - 10'd1) : lz;
               sum = sum << sh;
               e   = e - {5'd0, sh};
            end
            rem = sum[2:0];
            m   = sum[27:3];
            if (rem > 3'd4 || (rem == 3'd4 && m[0])) begin
               m = m + 25'd1;
            end
            if (m[24]) begin
               m = m >> 1;
               e = e + 10'd1;
            end
            if (e >= 10'd255) begin
               r = {sa, 8'hFF, 23'd0};
            end else begin
               r = {sa, (m[23] ? e[7:0] : 8'd0), m[22:0]};
            end
         end
      end
      return r;
   endfunction

   logic [31:0]       acc_ff, acc_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ldpa_pkg::rsp_type rsp_ff, rsp_in;
   logic              take;

   assign item_ready = !rsp_valid_ff || rsp_ready;
   assign take       = item_valid && item_ready;

   always_comb begin
      acc_in = fp32_add(item_data.restart ? ldpa_pkg::ZERO_CODE : acc_ff, item_data.product);
      rsp_in.accumulated_bits = acc_in;
      rsp_in.product_bits     = item_data.product;
      rsp_valid_in = take || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= ldpa_pkg::ZERO_CODE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            acc_ff <= acc_in;
         end
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/log_domain_product_accumulate.sv]
// Top level of the log-domain product accumulator: front, queue and back stages.
// Depends on ldpa_pkg, ldpa_front, ldpa_queue and ldpa_back.
//
//   channel | ports                       | payload
//   request | req_valid req_ready req_data | ldpa_pkg::req_type
//   result  | rsp_valid rsp_ready rsp_data | ldpa_pkg::rsp_type
//
// One request per cycle sustained while rsp_ready is high; a request is registered
// in the front stage, written into the queue, then registered with its result
// in the back stage, where the accumulator add is combinational.
// Synchronous reset loads the accumulator with the zero code and empties all stages.
// A result stall fills the two-entry queue before the request side is held.
module log_domain_product_accumulate (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ldpa_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ldpa_pkg::rsp_type rsp_data
);

   logic               f_valid, f_ready, b_valid, b_ready;
   ldpa_pkg::item_type f_data, b_data;

   ldpa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .item_valid (f_valid),
      .item_ready (f_ready),
      .item_data  (f_data)
   );

   ldpa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_data),
      .pop_valid  (b_valid),
      .pop_ready  (b_ready),
      .pop_data   (b_data)
   );

   ldpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (b_valid),
      .item_ready (b_ready),
      .item_data  (b_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
